/* hdl/fpe_pkg.sv */
`default_nettype none
package fpe_pkg;
   typedef struct packed {
      logic [7:0]  fmt_char;
      logic [63:0] arg_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_char;
      logic        is_count;
      logic [15:0] char_count;
      logic        last;
   } rsp_type;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_D       = 8'h64;
   localparam logic [7:0] CH_I       = 8'h69;
   localparam logic [7:0] CH_U       = 8'h75;
   localparam logic [7:0] CH_L       = 8'h6c;
   localparam logic [7:0] CH_O       = 8'h6f;
   localparam logic [7:0] CH_X       = 8'h78;
   localparam logic [7:0] CH_UX      = 8'h58;
   localparam logic [7:0] CH_P       = 8'h70;
   localparam logic [7:0] CH_C       = 8'h63;
   localparam logic [7:0] CH_S       = 8'h73;

   localparam logic [1:0] RADIX_10 = 2'd0;
   localparam logic [1:0] RADIX_8  = 2'd1;
   localparam logic [1:0] RADIX_16 = 2'd2;

   // datapath commands
   typedef struct packed {
      logic        load;      // load value and radix
      logic [63:0] value;
      logic [1:0]  radix;
      logic        upper;
      logic        step;      // one divide step, pushes digit when complete
      logic        pop;       // drop top digit
   } cmd_type;

   typedef struct packed {
      logic       zero;       // value reached zero
      logic       empty;      // no digits stacked
      logic       full;
      logic       busy;       // decimal divide step in progress
      logic       one;        // one digit left
      logic [7:0] digit_char;
   } sts_type;

   function automatic logic [7:0] digit_to_char(input logic [3:0] d, input logic upper);
      logic [7:0] r;
      if (d < 4'd10) r = CH_ZERO + {4'd0, d};
      else r = (upper ? CH_UA : CH_LA) + {4'd0, d} - 8'd10;
      return r;
   endfunction
endpackage
`default_nettype wire

/* hdl/fpe_datapath.sv */
`default_nettype none
module fpe_datapath #(
   parameter int DIGIT_SLOTS = 22
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire fpe_pkg::cmd_type cmd,
   output fpe_pkg::sts_type     sts
);
   localparam int DW = $clog2(DIGIT_SLOTS + 1);
   localparam int AW = $clog2(DIGIT_SLOTS);
   localparam logic [19:0] RECIP_10 = 20'hCCCCD;

   logic [63:0]   value_ff, value_in;
   logic [1:0]    radix_ff, radix_in;
   logic          upper_ff, upper_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [1:0]    phase_ff, phase_in;
   logic [3:0]    part_ff, part_in;
   logic [3:0]    stack_ff [DIGIT_SLOTS];
   logic [63:0]   quot;
   logic [3:0]    rem;
   logic [1:0]    phase_step;
   logic          push;
   logic [19:0]   dividend;
   logic [39:0]   prod;
   logic [15:0]   chunk_q;
   logic [3:0]    chunk_rem;

   // divide by ten one 16-bit chunk per cycle while stepping, most significant chunk first
   assign dividend  = {(phase_ff == 2'd0) ? 4'd0 : part_ff, value_ff[63:48]};
   assign prod      = dividend * RECIP_10;
   assign chunk_q   = prod[38:23];
   assign chunk_rem = 4'(dividend - ({1'b0, chunk_q, 3'd0} + {3'd0, chunk_q, 1'b0}));

   always_comb begin
      quot       = value_ff;
      rem        = 4'd0;
      phase_step = 2'd0;
      push       = 1'b1;
      case (radix_ff)
         fpe_pkg::RADIX_8: begin
            quot = {3'd0, value_ff[63:3]};
            rem  = {1'b0, value_ff[2:0]};
         end
         fpe_pkg::RADIX_16: begin
            quot = {4'd0, value_ff[63:4]};
            rem  = value_ff[3:0];
         end
         default: begin
            quot       = {value_ff[47:0], chunk_q};
            rem        = chunk_rem;
            phase_step = phase_ff + 2'd1;
            push       = (phase_ff == 2'd3);
         end
      endcase
   end

   always_comb begin
      value_in = value_ff;
      radix_in = radix_ff;
      upper_in = upper_ff;
      depth_in = depth_ff;
      phase_in = phase_ff;
      part_in  = part_ff;
      if (cmd.load) begin
         value_in = cmd.value;
         radix_in = cmd.radix;
         upper_in = cmd.upper;
         depth_in = '0;
         phase_in = 2'd0;
      end else if (cmd.step) begin
         value_in = quot;
         part_in  = rem;
         phase_in = phase_step;
         if (push) depth_in = depth_ff + DW'(1);
      end else if (cmd.pop) begin
         depth_in = depth_ff - DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      radix_ff <= radix_in;
      upper_ff <= upper_in;
      part_ff  <= part_in;
      if (reset) begin
         depth_ff <= '0;
         phase_ff <= 2'd0;
      end else begin
         depth_ff <= depth_in;
         phase_ff <= phase_in;
      end
      if (cmd.step && !cmd.load && push && depth_ff < DW'(DIGIT_SLOTS))
         stack_ff[depth_ff[AW-1:0]] <= rem;
   end

   logic [DW-1:0] top;
   assign top = depth_ff - DW'(1);
   assign sts.zero  = (value_ff == 64'd0);
   assign sts.empty = (depth_ff == '0);
   assign sts.full  = (depth_ff == DW'(DIGIT_SLOTS));
   assign sts.busy  = (phase_ff != 2'd0);
   assign sts.one   = (depth_ff == DW'(1));
   assign sts.digit_char = fpe_pkg::digit_to_char(stack_ff[top[AW-1:0]], upper_ff);
endmodule
`default_nettype wire

/* hdl/fpe_control.sv */
`default_nettype none
module fpe_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire fpe_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output fpe_pkg::rsp_type      rsp_data,
   output fpe_pkg::cmd_type      cmd,
   input  wire fpe_pkg::sts_type sts
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic        pend_ff, pend_in;
   logic [15:0] count_ff, count_in;
   logic        ovalid_ff, ovalid_in;
   fpe_pkg::rsp_type odata_ff, odata_in;
   logic [15:0] bumped;
   logic        acc, take, free;
   logic [7:0]  c;
   logic [63:0] a;
   logic [31:0] neg;

   assign c = req_data.fmt_char;
   assign a = req_data.arg_value;
   assign neg = 32'd0 - a[31:0];
   assign bumped = (count_ff == 16'hffff) ? count_ff : count_ff + 16'd1;
   assign take = ovalid_ff && !rsp_stall;
   assign free = !ovalid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && free);
   assign acc = req_valid && !req_stall;
   assign rsp_valid = ovalid_ff;
   assign rsp_data = odata_ff;

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      count_in  = count_ff;
      ovalid_in = take ? 1'b0 : ovalid_ff;
      odata_in  = odata_ff;
      cmd       = '0;
      cmd.radix = fpe_pkg::RADIX_10;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (c == 8'd0) begin
                  ovalid_in = 1'b1;
                  odata_in = '{out_char: 8'd0, is_count: 1'b1, char_count: count_ff, last: 1'b1};
                  pend_in = 1'b0;
                  count_in = 16'd0;
               end else if (pend_ff) begin
                  pend_in = 1'b0;
                  cmd.value = {32'd0, a[31:0]};
                  case (c)
                     fpe_pkg::CH_PERCENT, fpe_pkg::CH_C: begin
                        count_in = bumped;
                        ovalid_in = 1'b1;
                        odata_in = '{out_char: (c == fpe_pkg::CH_C) ? a[7:0] : fpe_pkg::CH_PERCENT,
                                     is_count: 1'b0, char_count: bumped, last: 1'b1};
                     end
                     fpe_pkg::CH_S: count_in = bumped;
                     fpe_pkg::CH_D, fpe_pkg::CH_I: begin
                        cmd.load = 1'b1;
                        state_in = ST_DIV;
                        if (a[31]) begin
                           cmd.value = {32'd0, neg};
                           count_in = bumped;
                           ovalid_in = 1'b1;
                           odata_in = '{out_char: fpe_pkg::CH_MINUS, is_count: 1'b0,
                                        char_count: bumped, last: 1'b0};
                        end
                     end
                     fpe_pkg::CH_U: begin
                        cmd.load = 1'b1; state_in = ST_DIV;
                     end
                     fpe_pkg::CH_L: begin
                        cmd.load = 1'b1; cmd.value = a; cmd.upper = 1'b1; state_in = ST_DIV;
                     end
                     fpe_pkg::CH_O: begin
                        cmd.load = 1'b1; cmd.radix = fpe_pkg::RADIX_8; state_in = ST_DIV;
                     end
                     fpe_pkg::CH_X: begin
                        cmd.load = 1'b1; cmd.radix = fpe_pkg::RADIX_16; state_in = ST_DIV;
                     end
                     fpe_pkg::CH_UX: begin
                        cmd.load = 1'b1; cmd.radix = fpe_pkg::RADIX_16; cmd.upper = 1'b1;
                        state_in = ST_DIV;
                     end
                     fpe_pkg::CH_P: begin
                        cmd.load = 1'b1; cmd.value = a; cmd.radix = fpe_pkg::RADIX_16;
                        cmd.upper = 1'b1; state_in = ST_DIV;
                     end
                     default: ;
                  endcase
               end else if (c == fpe_pkg::CH_PERCENT) begin
                  pend_in = 1'b1;
               end else begin
                  count_in = bumped;
                  ovalid_in = 1'b1;
                  odata_in = '{out_char: c, is_count: 1'b0, char_count: bumped, last: 1'b1};
               end
            end
         end
         ST_DIV: begin
            if (sts.busy) begin
               cmd.step = 1'b1;
            end else if (sts.empty && sts.zero) begin
               // zero value: single '0' digit
               cmd.step = 1'b1;
            end else if (sts.zero || sts.full) begin
               state_in = ST_EMIT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (free) begin
               cmd.pop = 1'b1;
               count_in = bumped;
               ovalid_in = 1'b1;
               odata_in = '{out_char: sts.digit_char, is_count: 1'b0, char_count: bumped,
                            last: sts.one};
               if (sts.one) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      odata_ff <= odata_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff <= 1'b0;
         count_ff <= 16'd0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         count_ff <= count_in;
         ovalid_ff <= ovalid_in;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("request taken while busy");
   a_count_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_count |-> rsp_data.last && rsp_data.out_char == 8'd0)
      else $error("bad count beat");
endmodule
`default_nettype wire

/* hdl/format_print_engine_top.sv */
// Echo, %%, %c and count beats are registered and appear in the cycle after acceptance.
// Conversions: a load, then divide steps that stack the digits (decimal divides in 16-bit
// chunks, octal and hex shift), a check that ends dividing, and one digit out per cycle
// while the output is not stalled. A new request is taken only in idle with the output free.
// Reset: synchronous, active high; clears state, pending flag, count and output valid.
`default_nettype none
module format_print_engine_top #(
   parameter int DIGIT_SLOTS = 22
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire fpe_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output fpe_pkg::rsp_type      rsp_data
);
   fpe_pkg::cmd_type cmd;
   fpe_pkg::sts_type sts;

   fpe_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .cmd, .sts
   );

   fpe_datapath #(.DIGIT_SLOTS(DIGIT_SLOTS)) u_dp (
      .clock, .reset, .cmd, .sts
   );
endmodule
`default_nettype wire
